>>> rtl/rct_pkg.sv
// Shared types and constants for the reference count table.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package rct_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int ADDR_W   = 32;
	localparam int COUNT_W  = 16;
	localparam int SEQ_W    = 32;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;

	// s_tdata: address, amount
	localparam int S_FIELDS_W = ADDR_W + COUNT_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int S_PAD_W    = S_TDATA_W - S_FIELDS_W;

	// m_tdata: entry_id, entry_address, entry_count, table_empty, inserted_total
	localparam int M_FIELDS_W = SEQ_W + ADDR_W + COUNT_W + 1 + SEQ_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MODIFY = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SWEEP  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RESERVED  = 2'd3;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_EXEC
	} fsm_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture accepted item, restart scan
		logic step;   // compare one entry
		logic exec;   // apply operation, load result register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic needs_scan;  // incoming command looks up by address
		logic scan_last;   // current scan entry is the final one
		logic out_free;    // result register can take a new item
	} dp_status_t;

endpackage

`default_nettype wire

>>> rtl/rct_ctrl.sv
// Sequencer for the reference count table: accept, scan, execute.
// Depends on rct_pkg for the state and command/status types.
`default_nettype none

module rct_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire rct_pkg::dp_status_t status,
	output rct_pkg::dp_cmd_t         cmd
);

	rct_pkg::fsm_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rct_pkg::FSM_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			rct_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = status.needs_scan ? rct_pkg::FSM_SCAN : rct_pkg::FSM_EXEC;
				end
			end
			rct_pkg::FSM_SCAN: begin
				cmd.step = 1'b1;
				if (status.scan_last) begin
					state_nx = rct_pkg::FSM_EXEC;
				end
			end
			rct_pkg::FSM_EXEC: begin
				if (status.out_free) begin
					cmd.exec = 1'b1;
					state_nx = rct_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_nx = rct_pkg::FSM_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/rct_datapath.sv
// Entry storage, address scan, update logic and result register.
// Depends on rct_pkg; driven by rct_ctrl through dp_cmd_t.
`default_nettype none

module rct_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire rct_pkg::dp_cmd_t                      cmd,
	output rct_pkg::dp_status_t                        status,
	input  wire logic        [rct_pkg::CMD_W-1:0]      in_command,
	input  wire logic        [rct_pkg::ADDR_W-1:0]     in_address,
	input  wire logic signed [rct_pkg::COUNT_W-1:0]    in_amount,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic             [rct_pkg::STATUS_W-1:0]   out_status,
	output logic             [rct_pkg::SEQ_W-1:0]      out_id,
	output logic             [rct_pkg::ADDR_W-1:0]     out_address,
	output logic signed      [rct_pkg::COUNT_W-1:0]    out_count,
	output logic                                       out_empty,
	output logic             [rct_pkg::SEQ_W-1:0]      out_total
);

	localparam int D = rct_pkg::TABLE_DEPTH;

	// captured item
	logic        [rct_pkg::CMD_W-1:0]   cmd_q;
	logic        [rct_pkg::ADDR_W-1:0]  addr_q;
	logic signed [rct_pkg::COUNT_W-1:0] amount_q;

	// table
	logic        [D-1:0]                valid_q;
	logic        [rct_pkg::ADDR_W-1:0]  addr_mem  [D];
	logic signed [rct_pkg::COUNT_W-1:0] refs_mem  [D];
	logic        [rct_pkg::SEQ_W-1:0]   seq_mem   [D];
	logic        [rct_pkg::SEQ_W-1:0]   counter_q;

	// scan state
	logic        [rct_pkg::IDX_W-1:0]   scan_idx_q;
	logic                               hit_q;
	logic        [rct_pkg::IDX_W-1:0]   hit_idx_q;
	logic        [rct_pkg::SEQ_W-1:0]   best_seq_q;
	logic signed [rct_pkg::COUNT_W-1:0] best_refs_q;

	logic scan_match;

	assign scan_match = valid_q[scan_idx_q] && (addr_mem[scan_idx_q] == addr_q) &&
		(!hit_q || (seq_mem[scan_idx_q] > best_seq_q));

	assign status.needs_scan = (in_command == rct_pkg::CMD_REMOVE) ||
		(in_command == rct_pkg::CMD_SEARCH) || (in_command == rct_pkg::CMD_MODIFY);
	assign status.scan_last  = (scan_idx_q == rct_pkg::IDX_W'(D - 1));
	assign status.out_free   = !out_valid || out_ready;

	// lowest free slot
	logic                      free_found;
	logic [rct_pkg::IDX_W-1:0] free_idx;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = D - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = rct_pkg::IDX_W'(i);
			end
		end
	end

	// saturating count update for modify
	logic signed [rct_pkg::COUNT_W:0]   sum;
	logic signed [rct_pkg::COUNT_W-1:0] sat;

	always_comb begin
		sum = {best_refs_q[rct_pkg::COUNT_W-1], best_refs_q} +
			{amount_q[rct_pkg::COUNT_W-1], amount_q};
		if (sum[rct_pkg::COUNT_W] != sum[rct_pkg::COUNT_W-1]) begin
			sat = sum[rct_pkg::COUNT_W] ? {1'b1, {(rct_pkg::COUNT_W-1){1'b0}}}
				: {1'b0, {(rct_pkg::COUNT_W-1){1'b1}}};
		end else begin
			sat = sum[rct_pkg::COUNT_W-1:0];
		end
	end

	// operation result
	logic        [D-1:0]                 valid_nx;
	logic        [rct_pkg::SEQ_W-1:0]    counter_nx;
	logic        [rct_pkg::STATUS_W-1:0] res_status;
	logic        [rct_pkg::SEQ_W-1:0]    res_id;
	logic        [rct_pkg::ADDR_W-1:0]   res_addr;
	logic signed [rct_pkg::COUNT_W-1:0]  res_count;
	logic                                do_insert;
	logic                                do_modify;

	always_comb begin
		valid_nx   = valid_q;
		counter_nx = counter_q;
		res_status = rct_pkg::ST_DONE;
		res_id     = '0;
		res_addr   = '0;
		res_count  = '0;
		do_insert  = 1'b0;
		do_modify  = 1'b0;
		unique case (cmd_q)
			rct_pkg::CMD_INSERT: begin
				if (!free_found || (counter_q == '1)) begin
					res_status = rct_pkg::ST_FULL;
				end else begin
					do_insert          = 1'b1;
					counter_nx         = counter_q + 1'b1;
					valid_nx[free_idx] = 1'b1;
					res_id             = counter_nx;
					res_addr           = addr_q;
					res_count          = amount_q;
				end
			end
			rct_pkg::CMD_REMOVE, rct_pkg::CMD_SEARCH, rct_pkg::CMD_MODIFY: begin
				if (!hit_q) begin
					res_status = rct_pkg::ST_NOT_FOUND;
				end else begin
					res_id    = best_seq_q;
					res_addr  = addr_q;
					res_count = best_refs_q;
					if (cmd_q == rct_pkg::CMD_MODIFY) begin
						do_modify = 1'b1;
						res_count = sat;
						if (sat == '0) begin
							valid_nx[hit_idx_q] = 1'b0;
						end
					end
					if (cmd_q == rct_pkg::CMD_REMOVE) begin
						valid_nx[hit_idx_q] = 1'b0;
					end
				end
			end
			rct_pkg::CMD_SWEEP: begin
				for (int i = 0; i < D; i++) begin
					valid_nx[i] = valid_q[i] && (refs_mem[i] != '0);
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			counter_q  <= '0;
			scan_idx_q <= '0;
			hit_q      <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_idx_q <= '0;
				hit_q      <= 1'b0;
			end else if (cmd.step) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (scan_match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.exec) begin
				valid_q   <= valid_nx;
				counter_q <= counter_nx;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= in_command;
			addr_q   <= in_address;
			amount_q <= in_amount;
		end
		if (cmd.step && scan_match) begin
			hit_idx_q   <= scan_idx_q;
			best_seq_q  <= seq_mem[scan_idx_q];
			best_refs_q <= refs_mem[scan_idx_q];
		end
		if (cmd.exec) begin
			if (do_insert) begin
				addr_mem[free_idx] <= addr_q;
				refs_mem[free_idx] <= amount_q;
				seq_mem[free_idx]  <= counter_nx;
			end
			if (do_modify) begin
				refs_mem[hit_idx_q] <= sat;
			end
			out_status  <= res_status;
			out_id      <= res_id;
			out_address <= res_addr;
			out_count   <= res_count;
			out_empty   <= ~|valid_nx;
			out_total   <= counter_nx;
		end
	end

endmodule

`default_nettype wire

>>> rtl/reference_count_table.sv
// Top level of the reference count table: stream ports, controller and datapath.
// Depends on rct_pkg, rct_ctrl and rct_datapath.
//
// Usage:
//   Input channel s_*: one table operation per item. s_tuser carries the
//   command (insert, remove, search, modify, sweep); s_tdata the address and
//   the amount (initial count or signed delta).
//   Output channel m_*: exactly one result item per input item, in order.
//   m_tuser carries the status; m_tdata the entry id, address, count, the
//   table-empty flag and the running insert total.
//   Timing: insert, sweep and unknown commands pass through accept and
//   execute only. Remove, search and modify scan the table one entry per
//   cycle through the datapath's single compare unit, between accept and
//   execute. The result is valid in the cycle after the execute step.
//   The result sits in an output register; the next item is accepted while it
//   waits. If the receiver stalls, the following item is scanned but holds in
//   the execute step until the output register frees up.
//   Reset clears all valid bits and the insert counter; no clearing pass.
`default_nettype none

module reference_count_table (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [rct_pkg::S_TDATA_W-1:0]     s_tdata,  // address, amount, zero pad
	input  wire logic [rct_pkg::CMD_W-1:0]         s_tuser,  // command
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// entry_id, entry_address, entry_count, table_empty, inserted_total, zero pad
	output logic      [rct_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic      [rct_pkg::STATUS_W-1:0]      m_tuser   // status
);

	rct_pkg::dp_cmd_t    dp_cmd;
	rct_pkg::dp_status_t dp_status;

	logic        [rct_pkg::SEQ_W-1:0]   out_id;
	logic        [rct_pkg::ADDR_W-1:0]  out_address;
	logic signed [rct_pkg::COUNT_W-1:0] out_count;
	logic                               out_empty;
	logic        [rct_pkg::SEQ_W-1:0]   out_total;

	rct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	rct_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.status      (dp_status),
		.in_command  (s_tuser),
		.in_address  (s_tdata[rct_pkg::ADDR_W-1:0]),
		.in_amount   (s_tdata[rct_pkg::ADDR_W +: rct_pkg::COUNT_W]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (m_tuser),
		.out_id      (out_id),
		.out_address (out_address),
		.out_count   (out_count),
		.out_empty   (out_empty),
		.out_total   (out_total)
	);

	assign m_tdata = {{rct_pkg::M_PAD_W{1'b0}}, out_total, out_empty, out_count,
		out_address, out_id};

endmodule

`default_nettype wire

>>> rtl/rct_checker.sv
// Port-level checks for the reference count table, bound to the top level.
// Depends on rct_pkg for field widths.
`default_nettype none

module rct_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [rct_pkg::M_TDATA_W-1:0] m_tdata,
	input wire logic [rct_pkg::STATUS_W-1:0]  m_tuser
);

	localparam int ENTRY_W = rct_pkg::SEQ_W + rct_pkg::ADDR_W + rct_pkg::COUNT_W;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// every item goes through the execute step before the next is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted in back-to-back cycles");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != rct_pkg::ST_RESERVED)
		else $error("reserved status code");

	// failed operations report no entry
	a_fail_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != rct_pkg::ST_DONE) |-> m_tdata[ENTRY_W-1:0] == '0)
		else $error("entry fields set on failed operation");

	// a new result comes out of the execute cycle, when the input is held off
	a_result_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a pending item");

endmodule

bind reference_count_table rct_checker u_rct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

>>> test/tb_reference_count_table.sv
// Self-checking testbench for reference_count_table: directed and random table operations.
// Depends on rct_pkg and the reference_count_table RTL. It predicts every result and checks it.
`default_nettype none

module tb_reference_count_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [rct_pkg::CMD_W-1:0] CMD_NOP_FIRST = rct_pkg::CMD_SWEEP + 3'd1;
	localparam logic [rct_pkg::CMD_W-1:0] CMD_NOP_LAST  = '1;

	localparam int COUNT_MAX = 2 ** (rct_pkg::COUNT_W - 1) - 1;
	localparam int COUNT_MIN = -(2 ** (rct_pkg::COUNT_W - 1));

	localparam int RANDOM_ITEMS = 1530;
	localparam int QUIET_TAIL   = 250;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 2 * rct_pkg::TABLE_DEPTH + 8;

	// m_tdata layout, lowest bit up
	localparam int ID_LSB    = 0;
	localparam int ADDR_LSB  = ID_LSB + rct_pkg::SEQ_W;
	localparam int COUNT_LSB = ADDR_LSB + rct_pkg::ADDR_W;
	localparam int EMPTY_BIT = COUNT_LSB + rct_pkg::COUNT_W;
	localparam int TOTAL_LSB = EMPTY_BIT + 1;

	typedef struct {
		logic [rct_pkg::STATUS_W-1:0]       status;
		logic [rct_pkg::SEQ_W-1:0]          id;
		logic [rct_pkg::ADDR_W-1:0]         addr;
		logic signed [rct_pkg::COUNT_W-1:0] count;
		logic                               empty;
		logic [rct_pkg::SEQ_W-1:0]          total;
	} table_result_t;

	// Mirror of the table contents plus the queue of results still owed by the block.
	class refcount_mirror;
		bit                                 slot_used [rct_pkg::TABLE_DEPTH];
		logic [rct_pkg::ADDR_W-1:0]         slot_addr [rct_pkg::TABLE_DEPTH];
		logic signed [rct_pkg::COUNT_W-1:0] slot_refs [rct_pkg::TABLE_DEPTH];
		logic [rct_pkg::SEQ_W-1:0]          slot_seq  [rct_pkg::TABLE_DEPTH];
		logic [rct_pkg::SEQ_W-1:0]          inserts;
		table_result_t                      due_results[$];
		int                                 mismatches;

		function new();
			foreach (slot_used[i]) begin
				slot_used[i] = 1'b0;
				slot_addr[i] = '0;
				slot_refs[i] = '0;
				slot_seq[i]  = '0;
			end
			inserts    = '0;
			mismatches = 0;
		endfunction

		// newest valid entry for an address is the one with the highest id
		function int newest_match(logic [rct_pkg::ADDR_W-1:0] a);
			int hit;
			hit = -1;
			for (int i = 0; i < rct_pkg::TABLE_DEPTH; i++) begin
				if (slot_used[i] && slot_addr[i] == a &&
						(hit < 0 || slot_seq[i] > slot_seq[hit]))
					hit = i;
			end
			return hit;
		endfunction

		function void apply_op(logic [rct_pkg::CMD_W-1:0] cmd, logic [rct_pkg::ADDR_W-1:0] a,
				logic signed [rct_pkg::COUNT_W-1:0] amt);
			table_result_t r;
			int slot;
			int sum;
			r.status = rct_pkg::ST_DONE;
			r.id     = '0;
			r.addr   = '0;
			r.count  = '0;
			slot     = -1;
			case (cmd)
				rct_pkg::CMD_INSERT: begin
					for (int i = 0; i < rct_pkg::TABLE_DEPTH; i++)
						if (!slot_used[i] && slot < 0)
							slot = i;
					if (slot < 0 || inserts == '1) begin
						r.status = rct_pkg::ST_FULL;
					end else begin
						inserts         = inserts + 1'b1;
						slot_used[slot] = 1'b1;
						slot_addr[slot] = a;
						slot_refs[slot] = amt;
						slot_seq[slot]  = inserts;
						r.id            = inserts;
						r.addr          = a;
						r.count         = amt;
					end
				end
				rct_pkg::CMD_REMOVE, rct_pkg::CMD_SEARCH, rct_pkg::CMD_MODIFY: begin
					slot = newest_match(a);
					if (slot < 0) begin
						r.status = rct_pkg::ST_NOT_FOUND;
					end else begin
						if (cmd == rct_pkg::CMD_MODIFY) begin
							sum = int'(slot_refs[slot]) + int'(amt);
							if (sum > COUNT_MAX)
								sum = COUNT_MAX;
							if (sum < COUNT_MIN)
								sum = COUNT_MIN;
							slot_refs[slot] = rct_pkg::COUNT_W'(sum);
							if (sum == 0)
								slot_used[slot] = 1'b0;
						end
						r.id    = slot_seq[slot];
						r.addr  = slot_addr[slot];
						r.count = slot_refs[slot];
						if (cmd == rct_pkg::CMD_REMOVE)
							slot_used[slot] = 1'b0;
					end
				end
				rct_pkg::CMD_SWEEP: begin
					foreach (slot_used[i])
						if (slot_used[i] && slot_refs[i] == '0)
							slot_used[i] = 1'b0;
				end
				default: ;
			endcase
			r.empty = 1'b1;
			foreach (slot_used[i])
				if (slot_used[i])
					r.empty = 1'b0;
			r.total = inserts;
			due_results.push_back(r);
		endfunction

		function void field_check(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void match_result(logic [rct_pkg::STATUS_W-1:0] st,
				logic [rct_pkg::M_TDATA_W-1:0] d);
			table_result_t w;
			if (due_results.size() == 0) begin
				$error("unexpected result item: status 0x%0h, data 0x%0h", st, d);
				mismatches++;
				return;
			end
			w = due_results.pop_front();
			field_check("status", 64'(w.status), 64'(st));
			field_check("entry_id", 64'(w.id), 64'(d[ID_LSB +: rct_pkg::SEQ_W]));
			field_check("entry_address", 64'(w.addr), 64'(d[ADDR_LSB +: rct_pkg::ADDR_W]));
			field_check("entry_count", 64'(unsigned'(w.count)),
				64'(d[COUNT_LSB +: rct_pkg::COUNT_W]));
			field_check("table_empty", 64'(w.empty), 64'(d[EMPTY_BIT]));
			field_check("inserted_total", 64'(w.total), 64'(d[TOTAL_LSB +: rct_pkg::SEQ_W]));
		endfunction
	endclass

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [rct_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
	logic [rct_pkg::CMD_W-1:0]       s_tuser  = rct_pkg::CMD_SWEEP;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [rct_pkg::M_TDATA_W-1:0]   m_tdata;
	logic [rct_pkg::STATUS_W-1:0]    m_tuser;

	bit             idle_on    = 1'b1;
	int             stall_left = 0;
	int             cycles     = 0;
	refcount_mirror mirror     = new();

	reference_count_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: check accepted items, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			mirror.match_result(m_tuser, m_tdata);
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic push_op(logic [rct_pkg::CMD_W-1:0] cmd, logic [rct_pkg::ADDR_W-1:0] a,
			logic signed [rct_pkg::COUNT_W-1:0] amt);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= rct_pkg::S_TDATA_W'({amt, a});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		mirror.apply_op(cmd, a, amt);
	endtask

	initial begin
		logic [rct_pkg::ADDR_W-1:0]         addr_pool [8];
		logic [rct_pkg::ADDR_W-1:0]         a;
		logic signed [rct_pkg::COUNT_W-1:0] amt;
		logic [rct_pkg::CMD_W-1:0]          cmd;
		int                                 pick;
		int                                 ins_cut;
		int                                 rem_cut;
		bit                                 draining;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: count extremes, duplicate addresses, saturation, zero count, sweep
		push_op(rct_pkg::CMD_INSERT, '0, rct_pkg::COUNT_W'(COUNT_MAX));
		push_op(rct_pkg::CMD_INSERT, '1, rct_pkg::COUNT_W'(COUNT_MIN));
		push_op(rct_pkg::CMD_INSERT, 32'hA5A5_5A5A, '0);
		push_op(rct_pkg::CMD_INSERT, 32'hA5A5_5A5A, 16'sd5);
		push_op(rct_pkg::CMD_SEARCH, 32'hA5A5_5A5A, '0);
		push_op(rct_pkg::CMD_MODIFY, '1, -16'sd1);
		push_op(rct_pkg::CMD_MODIFY, '0, 16'sd1);
		push_op(rct_pkg::CMD_MODIFY, 32'hA5A5_5A5A, -16'sd5);
		push_op(rct_pkg::CMD_SEARCH, 32'hA5A5_5A5A, '0);
		push_op(rct_pkg::CMD_SWEEP, '0, '0);
		push_op(rct_pkg::CMD_SEARCH, 32'hA5A5_5A5A, '0);
		push_op(rct_pkg::CMD_MODIFY, 32'hA5A5_5A5A, 16'sd3);
		push_op(rct_pkg::CMD_REMOVE, 32'hA5A5_5A5A, '0);
		push_op(rct_pkg::CMD_REMOVE, '0, '0);
		push_op(rct_pkg::CMD_REMOVE, '1, '1);
		push_op(rct_pkg::CMD_SEARCH, '1, '0);
		push_op(rct_pkg::CMD_SWEEP, '1, '1);
		for (int c = CMD_NOP_FIRST; c <= CMD_NOP_LAST; c++)
			push_op(rct_pkg::CMD_W'(c), 32'h1234_5678, 16'sd7);
		push_op(rct_pkg::CMD_INSERT, 32'h1234_5678, -16'sd1);
		push_op(rct_pkg::CMD_REMOVE, 32'h1234_5678, '0);

		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			addr_pool[i] = $urandom();

		// random: alternate fill and drain phases so the table goes full and empty
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_on  <= (n < RANDOM_ITEMS - QUIET_TAIL) && ((n / 60) % 4 != 3);
			draining = ((n / 120) % 2) == 1;
			ins_cut  = draining ? 15 : 50;
			rem_cut  = ins_cut + (draining ? 35 : 12);
			pick     = $urandom_range(0, 99);
			if (pick < ins_cut)
				cmd = rct_pkg::CMD_INSERT;
			else if (pick < rem_cut)
				cmd = rct_pkg::CMD_REMOVE;
			else if (pick < rem_cut + 20)
				cmd = rct_pkg::CMD_MODIFY;
			else if (pick < 93)
				cmd = rct_pkg::CMD_SEARCH;
			else if (pick < 98)
				cmd = rct_pkg::CMD_SWEEP;
			else
				cmd = rct_pkg::CMD_W'($urandom_range(CMD_NOP_FIRST, CMD_NOP_LAST));

			a = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, 7)] : $urandom();

			case ($urandom_range(0, 9))
				0, 1, 2, 3: amt = rct_pkg::COUNT_W'($urandom_range(0, 6) - 3);
				4, 5:       amt = rct_pkg::COUNT_W'($urandom_range(1, 4));
				6, 7:       amt = rct_pkg::COUNT_W'($urandom());
				8:          amt = rct_pkg::COUNT_W'(COUNT_MAX - $urandom_range(0, 3));
				default:    amt = rct_pkg::COUNT_W'(COUNT_MIN + $urandom_range(0, 3));
			endcase
			push_op(cmd, a, amt);
		end
		s_tvalid <= 1'b0;

		while (mirror.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mirror.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/rct_pkg.sv
rtl/rct_ctrl.sv
rtl/rct_datapath.sv
rtl/reference_count_table.sv
rtl/rct_checker.sv
test/tb_reference_count_table.sv
